// File: sv/dpc_pkg.sv
// ----------------------------------------------------------------------------
// Distinct permutation counter package
// Shared widths, constants, state types and the arithmetic unit's structs.
// ----------------------------------------------------------------------------
package dpc_pkg;

   localparam int SYM_W      = 8;
   localparam int POS_W      = 8;
   localparam int OCC_W      = 8;
   localparam int COUNT_W    = 64;
   localparam int DIGIT_W    = 8;
   localparam int ALPHABET   = 1 << SYM_W;
   localparam int MUL_STEPS  = COUNT_W / DIGIT_W;
   localparam int DIV_STEPS  = COUNT_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int DPC_MAX_LEN = 128;

   localparam logic [SYM_W-1:0] NEWLINE_SYM = SYM_W'(10);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MATH,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      ARITH_IDLE,
      ARITH_MUL,
      ARITH_DIV,
      ARITH_DONE
   } arith_state_type;

   typedef struct packed {
      logic             start;
      logic [POS_W-1:0] mult;
      logic [OCC_W-1:0] divisor;
   } arith_cmd_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } arith_stat_type;

endpackage

// File: sv/dpc_chan_if.sv
// ----------------------------------------------------------------------------
// Distinct permutation counter channels
// Valid/ready channels for the symbol words and the count words.
// ----------------------------------------------------------------------------
interface dpc_req_if import dpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

interface dpc_rsp_if import dpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] arrangements;
   logic               overflow;
   logic               word_done;

   modport source (output valid, output arrangements, output overflow, output word_done,
                   input ready);
   modport sink   (input valid, input arrangements, input overflow, input word_done,
                   output ready);
endinterface

// File: sv/dpc_arith.sv
// ----------------------------------------------------------------------------
// Distinct permutation counter arithmetic unit
// Multiplies the count by the position one byte per cycle, then, unless the
// product overflows, divides it by the occurrence count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dpc_arith import dpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  arith_cmd_type      cmd,
   input  logic [COUNT_W-1:0] count,
   output arith_stat_type     stat,
   output logic [COUNT_W-1:0] result
);

   localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

   arith_state_type      state_ff, state_in;
   logic [STEP_W-1:0]    step_ff;
   logic [COUNT_W-1:0]   acc_ff;
   logic [DIGIT_W-1:0]   carry_ff;
   logic [POS_W-1:0]     mult_ff;
   logic [OCC_W-1:0]     div_ff;
   logic [OCC_W-1:0]     rem_ff, rem_in;
   logic                 ovf_ff;
   logic [2*DIGIT_W-1:0] prod;
   logic [OCC_W:0]       trial;
   logic                 qbit;

   always_comb begin
      prod = (2*DIGIT_W)'(acc_ff[DIGIT_W-1:0]) * (2*DIGIT_W)'(mult_ff)
           + (2*DIGIT_W)'(carry_ff);
      trial = {rem_ff, acc_ff[COUNT_W-1]};
      qbit  = (trial >= {1'b0, div_ff});
      rem_in = qbit ? OCC_W'(trial - {1'b0, div_ff}) : trial[OCC_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ARITH_IDLE: begin
            if (cmd.start) state_in = ARITH_MUL;
         end
         ARITH_MUL: begin
            if (step_ff == MUL_LAST) begin
               state_in = (prod[2*DIGIT_W-1:DIGIT_W] != '0) ? ARITH_DONE : ARITH_DIV;
            end
         end
         ARITH_DIV: begin
            if (step_ff == DIV_LAST) state_in = ARITH_DONE;
         end
         ARITH_DONE: state_in = ARITH_IDLE;
         default:    state_in = ARITH_IDLE;
      endcase
   end

   always_comb begin
      stat.done = (state_ff == ARITH_DONE);
      stat.ovf  = ovf_ff;
      result    = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ARITH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ARITH_IDLE: begin
            acc_ff   <= count;
            mult_ff  <= cmd.mult;
            div_ff   <= cmd.divisor;
            carry_ff <= '0;
            rem_ff   <= '0;
            step_ff  <= '0;
            ovf_ff   <= 1'b0;
         end
         ARITH_MUL: begin
            acc_ff   <= {prod[DIGIT_W-1:0], acc_ff[COUNT_W-1:DIGIT_W]};
            carry_ff <= prod[2*DIGIT_W-1:DIGIT_W];
            ovf_ff   <= (step_ff == MUL_LAST) && (prod[2*DIGIT_W-1:DIGIT_W] != '0);
            step_ff  <= (step_ff == MUL_LAST) ? '0 : step_ff + 1'b1;
         end
         ARITH_DIV: begin
            acc_ff  <= {acc_ff[COUNT_W-2:0], qbit};
            rem_ff  <= rem_in;
            step_ff <= step_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: sv/distinct_permutation_counter.sv
// ----------------------------------------------------------------------------
// Distinct permutation counter
// Keeps the running count of distinct arrangements of a byte-wise word.
// ----------------------------------------------------------------------------
// Each symbol word returns one count word. After acceptance a symbol passes
// through a read of the occurrence store, the byte-serial multiply by the
// position, the bit-serial division by the occurrence count, the arithmetic
// unit's report and the load of the output register; no new symbol is
// accepted until it is through, and the divider loop is the longest step. A
// product that overflows skips the division, and a newline or a symbol
// arriving once the count has saturated skips the arithmetic altogether. One
// word is processed at a time; the next symbol is taken as soon as its
// predecessor has moved into the output register.
module distinct_permutation_counter import dpc_pkg::*; #(
   parameter int MAX_LEN = DPC_MAX_LEN
) (
   input logic        clock,
   input logic        reset,
   dpc_req_if.sink    req_ch,
   dpc_rsp_if.source  rsp_ch
);

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

   ctrl_state_type     state_ff, state_in;
   logic [SYM_W-1:0]   sym_ff;
   logic [OCC_W-1:0]   occ_mem [ALPHABET];
   logic [OCC_W-1:0]   occ_rd_ff;
   logic [ALPHABET-1:0] seen_ff;
   logic               seen_rd_ff;
   logic [POS_W-1:0]   position_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               sat_ff;
   logic               done_ff;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_ovf_ff;
   logic               rsp_done_ff;

   logic               take;
   logic               emit_go;
   logic               is_newline;
   logic [POS_W-1:0]   pos_next;
   logic [OCC_W-1:0]   occ_next;
   logic [OCC_W-1:0]   divisor;
   arith_cmd_type      arith_cmd;
   arith_stat_type     arith_stat;
   logic [COUNT_W-1:0] arith_result;

   always_comb begin
      is_newline = (sym_ff == NEWLINE_SYM);
      pos_next   = position_ff + 1'b1;
      occ_next   = (seen_rd_ff ? occ_rd_ff : '0) + 1'b1;
      divisor    = (occ_next == '0) ? OCC_W'(1) : occ_next;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_READ;
         end
         ST_READ: state_in = (is_newline || sat_ff) ? ST_EMIT : ST_MATH;
         ST_MATH: begin
            if (arith_stat.done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready      = (state_ff == ST_IDLE);
      take              = (state_ff == ST_IDLE) && req_ch.valid;
      emit_go           = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
      arith_cmd.start   = (state_ff == ST_READ) && !is_newline && !sat_ff;
      arith_cmd.mult    = pos_next;
      arith_cmd.divisor = divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         occ_rd_ff <= occ_mem[req_ch.symbol];
      end
      if ((state_ff == ST_READ) && !is_newline) begin
         occ_mem[sym_ff] <= occ_next;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sym_ff     <= req_ch.symbol;
         seen_rd_ff <= seen_ff[req_ch.symbol];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         position_ff <= '0;
         count_ff    <= COUNT_W'(1);
         sat_ff      <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         if (state_ff == ST_READ) begin
            done_ff <= is_newline || (pos_next >= MAX_POS);
            if (!is_newline) begin
               seen_ff[sym_ff] <= 1'b1;
               position_ff     <= pos_next;
            end
         end
         if ((state_ff == ST_MATH) && arith_stat.done) begin
            if (arith_stat.ovf) begin
               count_ff <= '1;
               sat_ff   <= 1'b1;
            end else begin
               count_ff <= arith_result;
            end
         end
         if (emit_go && done_ff) begin
            seen_ff     <= '0;
            position_ff <= '0;
            count_ff    <= COUNT_W'(1);
            sat_ff      <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_count_ff <= count_ff;
         rsp_ovf_ff   <= sat_ff;
         rsp_done_ff  <= done_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.arrangements = rsp_count_ff;
   assign rsp_ch.overflow     = rsp_ovf_ff;
   assign rsp_ch.word_done    = rsp_done_ff;

   dpc_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (arith_cmd),
      .count  (count_ff),
      .stat   (arith_stat),
      .result (arith_result)
   );

   // The arithmetic unit only finishes while the controller waits for it.
   assert property (@(posedge clock) disable iff (reset)
      arith_stat.done |-> (state_ff == ST_MATH))
      else $error("arithmetic result arrived outside the math phase");

   // A saturated count is never sent through the multiplier again.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATH) |-> !sat_ff)
      else $error("arithmetic started on a saturated count");

   // A word never stays open at its length limit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (position_ff < MAX_POS))
      else $error("word position reached the length limit while idle");

   // A closed word leaves the count cleared for the next one.
   assert property (@(posedge clock) disable iff (reset)
      (emit_go && done_ff) |=> ((count_ff == COUNT_W'(1)) && !sat_ff))
      else $error("word state not cleared after the closing word");

endmodule
